[rtl/trd_pkg.sv]
`timescale 1ns / 1ps

package trd_pkg;

  // position range of the letter counter
  localparam int unsigned PosBits = 20;

  localparam int unsigned Alpha    = 26;
  localparam int unsigned TriCount = Alpha * Alpha * Alpha;
  localparam int unsigned IdxW     = 15;
  localparam int unsigned OutW     = 20;
  localparam int unsigned DistW    = (PosBits > OutW) ? PosBits : OutW;

  localparam logic [OutW-1:0] OutMax = '1;

  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StProc
  } state_e;

  // trigram lookup request from the front end
  typedef struct packed {
    logic               hit;
    logic [IdxW-1:0]    idx;
    logic [PosBits-1:0] start;
  } tri_t;

endpackage

[rtl/trd_front.sv]
`timescale 1ns / 1ps

module trd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       text_byte_i,
  output trd_pkg::tri_t    tri_o
);

  localparam logic [trd_pkg::PosBits-1:0] PosLimit = '1;

  logic [4:0]                  older_q, older_d;
  logic [4:0]                  newer_q, newer_d;
  logic [trd_pkg::PosBits-1:0] count_q, count_d;
  logic                        is_letter;
  logic [4:0]                  code;
  logic                        take;

  always_comb begin
    is_letter = 1'b0;
    code      = '0;
    if (text_byte_i >= trd_pkg::ChUpperA && text_byte_i <= trd_pkg::ChUpperZ) begin
      is_letter = 1'b1;
      code      = 5'(text_byte_i - trd_pkg::ChUpperA);
    end else if (text_byte_i >= trd_pkg::ChLowerA && text_byte_i <= trd_pkg::ChLowerZ) begin
      is_letter = 1'b1;
      code      = 5'(text_byte_i - trd_pkg::ChLowerA);
    end
  end

  // letters past the end of the position range are dropped
  assign take = is_letter && (count_q < PosLimit);

  always_comb begin
    tri_o.hit   = take && (count_q >= trd_pkg::PosBits'(2));
    tri_o.idx   = trd_pkg::IdxW'(older_q) * trd_pkg::IdxW'(trd_pkg::Alpha * trd_pkg::Alpha)
                + trd_pkg::IdxW'(newer_q) * trd_pkg::IdxW'(trd_pkg::Alpha)
                + trd_pkg::IdxW'(code);
    tri_o.start = count_q - trd_pkg::PosBits'(2);
  end

  always_comb begin
    older_d = older_q;
    newer_d = newer_q;
    count_d = count_q;
    if (accept_i && take) begin
      older_d = newer_q;
      newer_d = code;
      count_d = count_q + trd_pkg::PosBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q <= '0;
      newer_q <= '0;
      count_q <= '0;
    end else begin
      older_q <= older_d;
      newer_q <= newer_d;
      count_q <= count_d;
    end
  end

endmodule

[rtl/trigram_repeat_distance_core.sv]
`timescale 1ns / 1ps
// results: an accepted byte's request is held through StProc, then the result registers strobe
// flow: busy is high in StProc, so the next byte waits for the table read-modify-write
//   (synchronous read, then update and write back)
// reset: a clearing pass writes all 17576 table entries, one per cycle,
//   holding busy high until it ends; the receiver cannot stall results

module trigram_repeat_distance_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [7:0]                text_byte_i,
  output logic                      result_valid_o,
  output logic [trd_pkg::OutW-1:0]  distance_o,
  output logic [trd_pkg::IdxW-1:0]  trigram_index_o,
  output logic [trd_pkg::OutW-1:0]  repeat_count_o
);

  localparam int unsigned EntW = trd_pkg::PosBits + 1;

  trd_pkg::state_e state_q, state_d;

  trd_pkg::tri_t tri_in;
  trd_pkg::tri_t tri_q;

  // entry: valid mark on top, last start position below
  logic [EntW-1:0] table_mem [trd_pkg::TriCount];
  logic [EntW-1:0] rd_q;

  logic [trd_pkg::IdxW-1:0] clr_cnt_q, clr_cnt_d;
  logic [trd_pkg::OutW-1:0] repeats_q, repeats_d;

  logic                     accept;
  logic                     rd_en;
  logic                     wr_en;
  logic [trd_pkg::IdxW-1:0] wr_addr;
  logic [EntW-1:0]          wr_data;
  logic                     emit;

  logic [trd_pkg::PosBits-1:0] gap;
  logic [trd_pkg::DistW-1:0]   dist_ext;
  logic [trd_pkg::OutW-1:0]    dist_sat;

  logic                     res_valid_q;
  logic [trd_pkg::OutW-1:0] res_dist_q;
  logic [trd_pkg::IdxW-1:0] res_idx_q;
  logic [trd_pkg::OutW-1:0] res_cnt_q;

  assign accept = start && !busy;

  trd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .text_byte_i (text_byte_i),
    .tri_o       (tri_in)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      trd_pkg::StClear: begin
        if (clr_cnt_q == trd_pkg::IdxW'(trd_pkg::TriCount - 1)) state_d = trd_pkg::StIdle;
      end
      trd_pkg::StIdle: begin
        if (start) state_d = trd_pkg::StProc;
      end
      trd_pkg::StProc: begin
        state_d = trd_pkg::StIdle;
      end
      default: state_d = trd_pkg::StIdle;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy    = 1'b1;
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = tri_q.idx;
    wr_data = {1'b1, tri_q.start};
    emit    = 1'b0;
    unique case (state_q)
      trd_pkg::StClear: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_q;
        wr_data = '0;
      end
      trd_pkg::StIdle: begin
        busy  = 1'b0;
        rd_en = start && tri_in.hit;
      end
      trd_pkg::StProc: begin
        wr_en = tri_q.hit;
        emit  = tri_q.hit && rd_q[EntW-1];
      end
      default: busy = 1'b1;
    endcase
  end

  always_comb begin
    gap      = tri_q.start - rd_q[trd_pkg::PosBits-1:0];
    dist_ext = trd_pkg::DistW'(gap);
    dist_sat = (dist_ext > trd_pkg::DistW'(trd_pkg::OutMax)) ? trd_pkg::OutMax
                                                              : trd_pkg::OutW'(dist_ext);
  end

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    if (state_q == trd_pkg::StClear) clr_cnt_d = clr_cnt_q + trd_pkg::IdxW'(1);
    repeats_d = repeats_q;
    if (emit && repeats_q != trd_pkg::OutMax) repeats_d = repeats_q + trd_pkg::OutW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= trd_pkg::StClear;
      clr_cnt_q   <= '0;
      repeats_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      repeats_q   <= repeats_d;
      res_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) tri_q <= tri_in;
    if (emit) begin
      res_dist_q <= dist_sat;
      res_idx_q  <= tri_q.idx;
      res_cnt_q  <= repeats_d;
    end
  end

  // table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) table_mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= table_mem[tri_in.idx];
  end

  assign result_valid_o  = res_valid_q;
  assign distance_o      = res_dist_q;
  assign trigram_index_o = res_idx_q;
  assign repeat_count_o  = res_cnt_q;

endmodule
